// ===== src/scfill_pkg.sv =====
// ----------------------------------------------------------------------------
// scfill_pkg: shared types and constants for the scanline polygon fill core
// Edge record, sort-chain control, state codes and dimension clamping.
// ----------------------------------------------------------------------------
package scfill_pkg;

	localparam int MAX_EDGES  = 16;
	localparam int FRAC_BITS  = 16;
	localparam int COORD_BITS = 16;
	localparam int XW         = COORD_BITS + FRAC_BITS;
	localparam int EIDX_W     = $clog2(MAX_EDGES);
	localparam int ECNT_W     = $clog2(MAX_EDGES + 1);
	localparam int MAX_SPANS  = 8;
	localparam int SIDX_W     = $clog2(MAX_SPANS);
	localparam int SCNT_W     = $clog2(MAX_SPANS + 1);
	localparam int COL_W      = 12;
	localparam int DIM_W      = 13;
	localparam int VTX_W      = 16;
	// divider: numerator |dx| << FRAC_BITS, denominator dy
	localparam int DW         = VTX_W + 1;
	localparam int QW         = DW + FRAC_BITS;
	localparam int DCNT_W     = $clog2(QW + 1);

	localparam logic [0:0] CFG_WIDTH  = 1'b0;
	localparam logic [0:0] CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [VTX_W-1:0] start_row;
		logic [VTX_W-1:0] end_row;
		logic [XW-1:0]    x_pos;
		logic [XW-1:0]    slope;
	} edge_rec_t;

	typedef struct packed {
		logic [VTX_W-1:0] xa;
		logic [VTX_W-1:0] ya;
		logic [VTX_W-1:0] xb;
		logic [VTX_W-1:0] yb;
	} seg_t;

	typedef struct packed {
		logic clear;
		logic shift;
	} sort_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE,
		ST_DIV,
		ST_ROT,
		ST_DRAIN,
		ST_SCAN,
		ST_FIN,
		ST_END,
		ST_EMIT
	} state_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) r = DIM_W'(1);
		else if (v > DIM_W'(4096)) r = DIM_W'(4096);
		return r;
	endfunction

endpackage

// ===== src/scanline_polygon_fill_core.sv =====
// ----------------------------------------------------------------------------
// scanline_polygon_fill_core: scanline fill with an active edge ring
// Builds a polygon edge list from vertex items and emits filled spans per row.
// ----------------------------------------------------------------------------
// Usage:
//  s_* carries items: tuser = kind (0 vertex, 1 next scanline), tlast marks
//  the closing vertex, tdata = {vertex_y, vertex_x}. m_* carries span items,
//  tlast on the final item of a row, tuser = span_valid.
//  A vertex item is accepted and wrapped up; for each edge it adds (at most
//  two) it takes a setup step and a run of the bit-serial slope divider;
//  dropped edges skip the divider. A row item rotates all MAX_EDGES edge cells
//  through the head cell, lets the insertion-sort chain settle, reads the
//  sorted columns out one a cycle and flushes the last parity group, closes
//  a span still open at the row end and then hands out 1 to 8 span items,
//  one a cycle while m_tready is high.
//  s_tready is high only while idle; one item is in work at a time.
//  A stalled m_tready holds the output register and the span readout.
//  Reset clears the edge count, vertex state, row counter and the overflow
//  flag and loads 640 x 480; edge cells hold no reset value.
//  Configuration writes take effect at once and belong to idle periods.
// ----------------------------------------------------------------------------
module scanline_polygon_fill_core
	import scfill_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [DIM_W-1:0] cfg_data,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [31:0]      s_tdata,   // vertex_x[15:0], vertex_y[31:16]
	input  logic             s_tlast,
	input  logic [0:0]       s_tuser,   // kind
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [39:0]      m_tdata,   // span_row, span_x_start, span_x_end, edges_dropped
	output logic             m_tlast,
	output logic [0:0]       m_tuser    // span_valid
);

	localparam logic [XW-1:0] X_HI = {1'b0, {(XW-1){1'b1}}};
	localparam logic [XW-1:0] X_LO = {1'b1, {(XW-1){1'b0}}};

	state_t state_q, state_d;

	logic [DIM_W-1:0] width_q, height_q, w_eff, h_eff;
	logic [ECNT_W-1:0] edge_total_q;
	logic [VTX_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic seen_q, ovf_q, past_q;
	logic [DIM_W-1:0] row_q;
	seg_t seg_a_q, seg_b_q;
	logic pend_a_q, pend_b_q;
	logic [ECNT_W-1:0] cnt_q, n_q;
	logic [SCNT_W-1:0] k_q;
	logic [SIDX_W-1:0] rd_q;
	logic [COL_W-1:0] gv_q, start_q;
	logic gp_q, gopen_q, draw_q;
	logic [COL_W-1:0] sp_start_q [MAX_SPANS];
	logic [COL_W-1:0] sp_end_q [MAX_SPANS];
	logic [VTX_W-1:0] nstart_q, nend_q, nx_q;
	logic neg_q;

	logic o_valid_q, o_last_q, o_span_q, o_ovf_q;
	logic [COL_W-1:0] o_row_q, o_xs_q, o_xe_q;

	logic in_acc, out_free;
	logic [VTX_W-1:0] vx, vy;

	assign w_eff    = eff_dim(width_q);
	assign h_eff    = eff_dim(height_q);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !o_valid_q || m_tready;
	assign vx       = s_tdata[15:0];
	assign vy       = s_tdata[31:16];

	// Current pending edge, ordered top to bottom
	seg_t cur;
	logic [VTX_W-1:0] ya_c, yb_c, xa_c, xb_c;
	logic signed [DW-1:0] dx;
	logic [DW-1:0] dy, dx_mag;
	logic drop_c, full_c;

	always_comb begin
		cur = pend_a_q ? seg_a_q : seg_b_q;
		if ($signed(cur.yb) < $signed(cur.ya)) begin
			ya_c = cur.yb; yb_c = cur.ya; xa_c = cur.xb; xb_c = cur.xa;
		end else begin
			ya_c = cur.ya; yb_c = cur.yb; xa_c = cur.xa; xb_c = cur.xb;
		end
		dx     = $signed({xb_c[VTX_W-1], xb_c}) - $signed({xa_c[VTX_W-1], xa_c});
		dy     = {yb_c[VTX_W-1], yb_c} - {ya_c[VTX_W-1], ya_c};
		dx_mag = dx[DW-1] ? DW'(-dx) : DW'(dx);
		drop_c = (ya_c == yb_c) || ya_c[VTX_W-1] ||
		         ($signed(ya_c) >= $signed({{(VTX_W-DIM_W){1'b0}}, h_eff}));
		full_c = edge_total_q >= ECNT_W'(MAX_EDGES);
	end

	// Slope divider
	logic div_start, div_done;
	logic [QW-1:0] quot;
	logic [XW-1:0] slope_sat;

	assign div_start = (state_q == ST_EDGE) && (pend_a_q || pend_b_q) && !drop_c && !full_c;

	scfill_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({dx_mag, {FRAC_BITS{1'b0}}}),
		.den    (dy),
		.done   (div_done),
		.quot   (quot)
	);

	always_comb begin
		if (neg_q) begin
			slope_sat = (quot > QW'(X_LO)) ? X_LO : XW'(-quot);
		end else begin
			slope_sat = (quot > QW'(X_HI)) ? X_HI : quot[XW-1:0];
		end
	end

	// Edge ring: cell 0 is the head, rotate toward it
	edge_rec_t ents [MAX_EDGES];
	edge_rec_t new_ent, wrap_ent;
	logic head_act, ins_valid;
	logic signed [XW:0] x_sum;
	logic [XW-1:0] x_upd;
	logic [COORD_BITS-1:0] col_raw;
	logic signed [VTX_W-1:0] y_s;

	assign new_ent = '{start_row: nstart_q, end_row: nend_q,
	                   x_pos: {nx_q, {FRAC_BITS{1'b0}}}, slope: slope_sat};

	always_comb begin
		y_s      = $signed({{(VTX_W-DIM_W){1'b0}}, row_q});
		head_act = (cnt_q < edge_total_q) && ($signed(ents[0].start_row) <= y_s) &&
		           (y_s < $signed(ents[0].end_row));
		x_sum    = $signed({ents[0].x_pos[XW-1], ents[0].x_pos}) +
		           $signed({ents[0].slope[XW-1], ents[0].slope});
		if (x_sum[XW] != x_sum[XW-1]) x_upd = x_sum[XW] ? X_LO : X_HI;
		else x_upd = x_sum[XW-1:0];
		wrap_ent = ents[0];
		if (head_act) wrap_ent.x_pos = x_upd;
		col_raw   = ents[0].x_pos[XW-1] ? '0 : ents[0].x_pos[XW-1:FRAC_BITS];
		ins_valid = (state_q == ST_ROT) &&
		            head_act && (col_raw < {{(COORD_BITS-DIM_W){1'b0}}, w_eff});
	end

	// Sort chain
	sort_ctl_t sort_ctl;
	logic             hv [MAX_EDGES];
	logic [COL_W-1:0] hc [MAX_EDGES];
	logic             pv [MAX_EDGES];
	logic [COL_W-1:0] pc [MAX_EDGES];

	for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cells
		edge_rec_t nxt;
		logic             rv;
		logic [COL_W-1:0] rc;
		logic             iv;
		logic [COL_W-1:0] ic;
		if (i == MAX_EDGES - 1) begin : g_tail
			assign nxt = wrap_ent;
			assign rv  = 1'b0;
			assign rc  = '0;
		end else begin : g_mid
			assign nxt = ents[i+1];
			assign rv  = hv[i+1];
			assign rc  = hc[i+1];
		end
		if (i == 0) begin : g_head
			assign iv = ins_valid;
			assign ic = col_raw[COL_W-1:0];
		end else begin : g_body
			assign iv = pv[i-1];
			assign ic = pc[i-1];
		end

		scfill_edge_cell u_edge (
			.clk      (clk),
			.load     (div_done && (edge_total_q[EIDX_W-1:0] == EIDX_W'(i))),
			.shift    (state_q == ST_ROT),
			.load_ent (new_ent),
			.next_ent (nxt),
			.ent      (ents[i])
		);

		scfill_sort_cell u_sort (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (sort_ctl),
			.in_valid    (iv),
			.in_col      (ic),
			.right_valid (rv),
			.right_col   (rc),
			.hold_valid  (hv[i]),
			.hold_col    (hc[i]),
			.pass_valid  (pv[i]),
			.pass_col    (pc[i])
		);
	end

	// Parity toggle request
	logic tog_en;
	logic [COL_W-1:0] tog_col;
	logic scan_step;

	assign scan_step = (state_q == ST_SCAN) && (cnt_q != n_q);

	always_comb begin
		tog_en  = 1'b0;
		tog_col = gv_q;
		if (scan_step) begin
			tog_en = gopen_q && gp_q && (hc[0] != gv_q);
		end else if (state_q == ST_FIN) begin
			tog_en = gopen_q && gp_q;
		end
	end

	// Next state
	logic emit_last;
	assign emit_last = (k_q == '0) || ({1'b0, rd_q} == k_q - 1'b1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (s_tuser == 1'b0) state_d = ST_EDGE;
					else if (row_q >= h_eff) state_d = ST_EMIT;
					else state_d = ST_ROT;
				end
			end
			ST_EDGE: begin
				if (!pend_a_q && !pend_b_q) state_d = ST_IDLE;
				else if (div_start) state_d = ST_DIV;
			end
			ST_DIV:   if (div_done) state_d = ST_EDGE;
			ST_ROT:   if (cnt_q == ECNT_W'(MAX_EDGES - 1)) state_d = ST_DRAIN;
			ST_DRAIN: if (cnt_q == ECNT_W'(MAX_EDGES - 1)) state_d = ST_SCAN;
			ST_SCAN:  if (cnt_q == n_q) state_d = ST_FIN;
			ST_FIN:   state_d = ST_END;
			ST_END:   state_d = ST_EMIT;
			ST_EMIT:  if (out_free && emit_last) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		s_tready       = (state_q == ST_IDLE);
		sort_ctl.clear = in_acc && (s_tuser == 1'b1);
		sort_ctl.shift = scan_step;
	end

	// Control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			width_q      <= DIM_W'(640);
			height_q     <= DIM_W'(480);
			edge_total_q <= '0;
			first_x_q    <= '0;
			first_y_q    <= '0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			seen_q       <= 1'b0;
			row_q        <= '0;
			ovf_q        <= 1'b0;
			pend_a_q     <= 1'b0;
			pend_b_q     <= 1'b0;
			past_q       <= 1'b0;
			cnt_q        <= '0;
			n_q          <= '0;
			k_q          <= '0;
			rd_q         <= '0;
			gopen_q      <= 1'b0;
			gp_q         <= 1'b0;
			draw_q       <= 1'b0;
			o_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				unique case (cfg_index)
					CFG_WIDTH:  width_q  <= cfg_data;
					CFG_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end

			// drop the taken item unless a new one replaces it
			if (o_valid_q && m_tready && state_q != ST_EMIT) o_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && s_tuser == 1'b0) begin
						// edge from previous vertex
						pend_a_q <= seen_q;
						seg_a_q  <= '{xa: prev_x_q, ya: prev_y_q, xb: vx, yb: vy};
						// closing edge back to the first vertex
						pend_b_q <= s_tlast;
						seg_b_q  <= '{xa: vx, ya: vy,
						              xb: seen_q ? first_x_q : vx,
						              yb: seen_q ? first_y_q : vy};
						if (!seen_q) begin
							edge_total_q <= '0;
							row_q        <= '0;
							first_x_q    <= vx;
							first_y_q    <= vy;
						end
						seen_q   <= !s_tlast;
						prev_x_q <= vx;
						prev_y_q <= vy;
					end else if (in_acc) begin
						past_q  <= (row_q >= h_eff);
						cnt_q   <= '0;
						n_q     <= '0;
						k_q     <= '0;
						rd_q    <= '0;
						gopen_q <= 1'b0;
						gp_q    <= 1'b0;
						draw_q  <= 1'b0;
					end
				end
				ST_EDGE: begin
					if (pend_a_q || pend_b_q) begin
						if (pend_a_q) pend_a_q <= 1'b0;
						else pend_b_q <= 1'b0;
						if (!drop_c && full_c) ovf_q <= 1'b1;
						nstart_q <= ya_c;
						nend_q   <= yb_c;
						nx_q     <= xa_c;
						neg_q    <= dx[DW-1];
					end
				end
				ST_DIV: begin
					if (div_done) edge_total_q <= edge_total_q + 1'b1;
				end
				ST_ROT: begin
					if (ins_valid) n_q <= n_q + 1'b1;
					cnt_q <= (cnt_q == ECNT_W'(MAX_EDGES - 1)) ? '0 : cnt_q + 1'b1;
				end
				ST_DRAIN: begin
					cnt_q <= (cnt_q == ECNT_W'(MAX_EDGES - 1)) ? '0 : cnt_q + 1'b1;
				end
				ST_SCAN: begin
					if (scan_step) begin
						cnt_q <= cnt_q + 1'b1;
						if (gopen_q && hc[0] == gv_q) begin
							gp_q <= !gp_q;
						end else begin
							gv_q    <= hc[0];
							gp_q    <= 1'b1;
							gopen_q <= 1'b1;
						end
					end
				end
				ST_FIN: ;
				ST_END: begin
					// open span runs to the right edge
					if (draw_q && k_q < SCNT_W'(MAX_SPANS)) begin
						sp_start_q[k_q[SIDX_W-1:0]] <= start_q;
						sp_end_q[k_q[SIDX_W-1:0]]   <= COL_W'(w_eff - 1'b1);
						k_q <= k_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						o_valid_q <= 1'b1;
						o_row_q   <= past_q ? '0 : row_q[COL_W-1:0];
						o_span_q  <= (k_q != '0);
						o_xs_q    <= (k_q != '0) ? sp_start_q[rd_q] : '0;
						o_xe_q    <= (k_q != '0) ? sp_end_q[rd_q] : '0;
						o_last_q  <= emit_last;
						o_ovf_q   <= ovf_q;
						rd_q      <= rd_q + 1'b1;
						if (emit_last && !past_q) row_q <= row_q + 1'b1;
					end else begin
						if (m_tready) o_valid_q <= 1'b0;
					end
				end
				default: ;
			endcase

			// parity toggle: open a span or close it
			if (tog_en) begin
				if (!draw_q) begin
					start_q <= tog_col;
					draw_q  <= 1'b1;
				end else begin
					draw_q <= 1'b0;
					if (k_q < SCNT_W'(MAX_SPANS)) begin
						sp_start_q[k_q[SIDX_W-1:0]] <= start_q;
						sp_end_q[k_q[SIDX_W-1:0]]   <= tog_col - 1'b1;
						k_q <= k_q + 1'b1;
					end
				end
			end
		end
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {3'b000, o_ovf_q, o_xe_q, o_xs_q, o_row_q};
	assign m_tlast  = o_last_q;
	assign m_tuser  = o_span_q;

	// Span count stays within the buffer
	a_span_cap: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= SCNT_W'(MAX_SPANS))
		else $error("span count beyond buffer");

	// A divide only starts with room in the edge ring
	a_div_room: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> edge_total_q < ECNT_W'(MAX_EDGES))
		else $error("edge written past ring capacity");

	// An empty-row item always closes its row
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> m_tlast)
		else $error("empty row item without last");

	// Row counter holds steady during rotation
	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROT) |=> $stable(row_q))
		else $error("row counter moved during rotation");

endmodule

// ===== src/scfill_edge_cell.sv =====
// ----------------------------------------------------------------------------
// scfill_edge_cell: one slot of the active edge ring
// Holds one edge record; loads a new edge or takes its neighbor's on rotate.
// ----------------------------------------------------------------------------
module scfill_edge_cell
	import scfill_pkg::*;
(
	input  logic      clk,
	input  logic      load,
	input  logic      shift,
	input  edge_rec_t load_ent,
	input  edge_rec_t next_ent,
	output edge_rec_t ent
);

	edge_rec_t ent_q;

	always_ff @(posedge clk) begin
		if (load) begin
			ent_q <= load_ent;
		end else if (shift) begin
			ent_q <= next_ent;
		end
	end

	assign ent = ent_q;

endmodule

// ===== src/scfill_sort_cell.sv =====
// ----------------------------------------------------------------------------
// scfill_sort_cell: one cell of the systolic insertion sorter
// Keep the smaller column, pass the larger one right; shift left on readout.
// ----------------------------------------------------------------------------
module scfill_sort_cell
	import scfill_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  sort_ctl_t        ctl,
	input  logic             in_valid,
	input  logic [COL_W-1:0] in_col,
	input  logic             right_valid,
	input  logic [COL_W-1:0] right_col,
	output logic             hold_valid,
	output logic [COL_W-1:0] hold_col,
	output logic             pass_valid,
	output logic [COL_W-1:0] pass_col
);

	logic             hold_valid_q;
	logic [COL_W-1:0] hold_col_q;
	logic             pass_valid_q;
	logic [COL_W-1:0] pass_col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			pass_valid_q <= 1'b0;
		end else if (ctl.clear) begin
			hold_valid_q <= 1'b0;
			pass_valid_q <= 1'b0;
		end else if (ctl.shift) begin
			hold_valid_q <= right_valid;
			hold_col_q   <= right_col;
			pass_valid_q <= 1'b0;
		end else if (in_valid) begin
			if (!hold_valid_q) begin
				hold_valid_q <= 1'b1;
				hold_col_q   <= in_col;
				pass_valid_q <= 1'b0;
			end else begin
				pass_valid_q <= 1'b1;
				if (in_col < hold_col_q) begin
					hold_col_q <= in_col;
					pass_col_q <= hold_col_q;
				end else begin
					pass_col_q <= in_col;
				end
			end
		end else begin
			pass_valid_q <= 1'b0;
		end
	end

	assign hold_valid = hold_valid_q;
	assign hold_col   = hold_col_q;
	assign pass_valid = pass_valid_q;
	assign pass_col   = pass_col_q;

endmodule

// ===== src/scfill_div.sv =====
// ----------------------------------------------------------------------------
// scfill_div: restoring divider for edge slopes
// One quotient bit per cycle, unsigned magnitudes.
// ----------------------------------------------------------------------------
module scfill_div
	import scfill_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [QW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quot
);

	logic              busy_q;
	logic              done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DW-1:0]     rem_q;
	logic [DW-1:0]     den_q;
	logic [QW-1:0]     num_q;
	logic [DW:0]       rem2;
	logic              ge;
	logic [DW:0]       diff;

	assign rem2 = {rem_q, num_q[QW-1]};
	assign ge   = rem2 >= {1'b0, den_q};
	assign diff = rem2 - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DCNT_W'(QW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == DCNT_W'(1));
			busy_q <= (cnt_q != DCNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : rem2[DW-1:0];
			num_q <= {num_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule
